### hw/rtl/tmtw_pkg.sv
`default_nettype none

package tmtw_pkg;

	localparam int unsigned DEF_SCREEN_WIDTH  = 80;
	localparam int unsigned DEF_SCREEN_HEIGHT = 25;

	localparam int unsigned MODE_W = 2;
	localparam int unsigned CHAR_W = 8;
	localparam int unsigned INDEX_W = 11;
	localparam int unsigned POS_W = 11;
	localparam int unsigned CELL_W = 16;
	localparam int unsigned ATTR_W = 8;

	// Depth of the command queue; a power of two.
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

	localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
	localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
	localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
	localparam logic [CHAR_W-1:0] CH_BLANK   = 8'h20;

	localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;
	localparam int unsigned TAB_STEP = 4;

	typedef enum logic [2:0] {
		OP_PUT     = 3'd0,
		OP_NEWLINE = 3'd1,
		OP_RETURN  = 3'd2,
		OP_TAB     = 3'd3,
		OP_READ    = 3'd4,
		OP_CLEAR   = 3'd5,
		OP_NOP     = 3'd6
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [CHAR_W-1:0]  char_code;
		logic [INDEX_W-1:0] cell_index;
	} cmd_t;

	typedef struct packed {
		logic              scrolled;
		logic [CELL_W-1:0] cell_value;
		logic [POS_W-1:0]  cursor_position;
	} result_t;

endpackage

`default_nettype wire

### hw/rtl/tmtw_front.sv
`default_nettype none

module tmtw_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// char_code [7:0], cell_index [18:8], zero fill [23:19]
	input  wire logic [23:0]                    s_tdata,
	// mode [1:0]
	input  wire logic [tmtw_pkg::MODE_W-1:0]    s_tuser,
	output logic                                cmd_valid,
	input  wire logic                           cmd_ready,
	output tmtw_pkg::cmd_t                      cmd
);

	localparam int unsigned PTR_W = $clog2(tmtw_pkg::QUEUE_DEPTH);

	tmtw_pkg::cmd_t        cmd_in;
	tmtw_pkg::cmd_t        queue_q [tmtw_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]      wr_ptr_q;
	logic [PTR_W-1:0]      rd_ptr_q;
	logic [PTR_W:0]        count_q;
	logic                  push;
	logic                  pop;

	always_comb begin
		cmd_in.char_code  = s_tdata[7:0];
		cmd_in.cell_index = s_tdata[18:8];
		case (s_tuser)
			tmtw_pkg::MODE_PUT: begin
				case (s_tdata[7:0])
					tmtw_pkg::CH_NEWLINE: cmd_in.op = tmtw_pkg::OP_NEWLINE;
					tmtw_pkg::CH_RETURN:  cmd_in.op = tmtw_pkg::OP_RETURN;
					tmtw_pkg::CH_TAB:     cmd_in.op = tmtw_pkg::OP_TAB;
					default:              cmd_in.op = tmtw_pkg::OP_PUT;
				endcase
			end
			tmtw_pkg::MODE_READ:  cmd_in.op = tmtw_pkg::OP_READ;
			tmtw_pkg::MODE_CLEAR: cmd_in.op = tmtw_pkg::OP_CLEAR;
			default:              cmd_in.op = tmtw_pkg::OP_NOP;
		endcase
	end

	assign s_tready  = (count_q != (PTR_W+1)'(tmtw_pkg::QUEUE_DEPTH));
	assign cmd_valid = (count_q != '0);
	assign cmd       = queue_q[rd_ptr_q];
	assign push      = s_tvalid && s_tready;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/tmtw_back.sv
`default_nettype none

module tmtw_back #(
	parameter int unsigned SCREEN_WIDTH  = tmtw_pkg::DEF_SCREEN_WIDTH,
	parameter int unsigned SCREEN_HEIGHT = tmtw_pkg::DEF_SCREEN_HEIGHT
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [tmtw_pkg::ATTR_W-1:0]   cfg_data,
	input  wire logic                          cmd_valid,
	output logic                               cmd_ready,
	input  wire tmtw_pkg::cmd_t                cmd,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output tmtw_pkg::result_t                  result
);

	localparam int unsigned CELLS  = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int unsigned ADDR_W = $clog2(CELLS);
	localparam int unsigned CNT_W  = $clog2(CELLS + 1);
	localparam int unsigned CMP_W  = (CNT_W > tmtw_pkg::INDEX_W) ? CNT_W : tmtw_pkg::INDEX_W;
	localparam int unsigned ROW_W  = $clog2(SCREEN_HEIGHT);
	localparam int unsigned COL_W  = $clog2(SCREEN_WIDTH);

	localparam logic [ADDR_W-1:0] W_A        = ADDR_W'(SCREEN_WIDTH);
	localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELLS - 1);
	localparam logic [ADDR_W-1:0] LAST_SRC   = ADDR_W'(CELLS - SCREEN_WIDTH - 1);
	localparam logic [ADDR_W-1:0] BOTTOM_ROW = ADDR_W'(CELLS - SCREEN_WIDTH);
	localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(SCREEN_HEIGHT - 1);

	typedef enum logic [6:0] {
		ST_INIT  = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_READ  = 7'b0000100,
		ST_FILL  = 7'b0001000,
		ST_COPY  = 7'b0010000,
		ST_DRAIN = 7'b0100000,
		ST_BLANK = 7'b1000000
	} state_t;

	function automatic logic [ADDR_W-1:0] lin_of(input logic [ROW_W-1:0] r,
			input logic [COL_W-1:0] c);
		return ADDR_W'(r) * W_A + ADDR_W'(c);
	endfunction

	state_t                         state_q, state_d;
	logic [ADDR_W-1:0]              addr_q, addr_d;
	logic [ADDR_W-1:0]              waddr_q, waddr_d;
	logic                           wpend_q, wpend_d;
	logic [ROW_W-1:0]               row_q, row_d;
	logic [COL_W-1:0]               col_q, col_d;
	logic [tmtw_pkg::ATTR_W-1:0]    attr_q;
	tmtw_pkg::result_t              out_q, out_d;
	logic                           out_valid_q;
	logic                           out_load;

	logic [tmtw_pkg::CELL_W-1:0]    mem_q [CELLS];
	logic [tmtw_pkg::CELL_W-1:0]    rd_data_q;
	logic                           mem_we, mem_re;
	logic [ADDR_W-1:0]              mem_wa, mem_ra;
	logic [tmtw_pkg::CELL_W-1:0]    mem_wd;

	logic [ADDR_W-1:0]              lin_cur;
	logic [COL_W:0]                 col_adv;
	logic                           row_inc;
	logic                           wrap;
	logic [ROW_W:0]                 row_adv;
	logic [COL_W-1:0]               col_nx;
	logic [ROW_W-1:0]               row_nx;
	logic                           scroll_nx;
	logic                           is_move;
	logic                           read_ok;
	logic                           pop;

	assign cfg_ready = 1'b1;
	assign cmd_ready = (state_q == ST_IDLE) && (!out_valid_q || m_tready);
	assign pop       = cmd_valid && cmd_ready;
	assign m_tvalid  = out_valid_q;
	assign result    = out_q;
	assign lin_cur   = lin_of(row_q, col_q);
	assign read_ok   = CMP_W'(cmd.cell_index) < CMP_W'(CELLS);

	always_comb begin
		row_inc = 1'b0;
		case (cmd.op)
			tmtw_pkg::OP_PUT:     col_adv = {1'b0, col_q} + 1'b1;
			tmtw_pkg::OP_NEWLINE: begin
				col_adv = '0;
				row_inc = 1'b1;
			end
			tmtw_pkg::OP_RETURN:  col_adv = '0;
			tmtw_pkg::OP_TAB:     col_adv = ({1'b0, col_q} + (COL_W+1)'(tmtw_pkg::TAB_STEP))
					& ~(COL_W+1)'(tmtw_pkg::TAB_STEP - 1);
			default:              col_adv = {1'b0, col_q};
		endcase
		wrap      = col_adv >= (COL_W+1)'(SCREEN_WIDTH);
		row_adv   = {1'b0, row_q} + (ROW_W+1)'(row_inc || wrap);
		scroll_nx = row_adv >= (ROW_W+1)'(SCREEN_HEIGHT);
		col_nx    = wrap ? '0 : col_adv[COL_W-1:0];
		row_nx    = row_adv[ROW_W-1:0];
	end

	always_comb begin
		state_d  = state_q;
		addr_d   = addr_q;
		waddr_d  = waddr_q;
		wpend_d  = wpend_q;
		row_d    = row_q;
		col_d    = col_q;
		out_load = 1'b0;
		out_d.cursor_position = tmtw_pkg::POS_W'(lin_cur);
		out_d.cell_value      = '0;
		out_d.scrolled        = 1'b0;
		mem_we   = 1'b0;
		mem_wa   = addr_q;
		mem_wd   = {attr_q, tmtw_pkg::CH_BLANK};
		mem_re   = 1'b0;
		mem_ra   = addr_q + W_A;
		is_move  = 1'b0;
		case (state_q)
			ST_INIT: begin
				mem_we = 1'b1;
				mem_wd = {tmtw_pkg::RESET_ATTR, tmtw_pkg::CH_BLANK};
				addr_d = addr_q + 1'b1;
				if (addr_q == LAST_CELL) begin
					addr_d  = '0;
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (pop) begin
					case (cmd.op)
						tmtw_pkg::OP_PUT: begin
							mem_we  = 1'b1;
							mem_wa  = lin_cur;
							mem_wd  = {attr_q, cmd.char_code};
							is_move = 1'b1;
						end
						tmtw_pkg::OP_NEWLINE, tmtw_pkg::OP_RETURN, tmtw_pkg::OP_TAB: begin
							is_move = 1'b1;
						end
						tmtw_pkg::OP_READ: begin
							if (read_ok) begin
								mem_re  = 1'b1;
								mem_ra  = ADDR_W'(cmd.cell_index);
								state_d = ST_READ;
							end else begin
								out_load = 1'b1;
							end
						end
						tmtw_pkg::OP_CLEAR: begin
							addr_d  = '0;
							state_d = ST_FILL;
						end
						default: begin
							out_load = 1'b1;
						end
					endcase
					if (is_move) begin
						if (scroll_nx) begin
							row_d   = LAST_ROW;
							col_d   = '0;
							addr_d  = '0;
							wpend_d = 1'b0;
							state_d = ST_COPY;
						end else begin
							row_d    = row_nx;
							col_d    = col_nx;
							out_load = 1'b1;
							out_d.cursor_position = tmtw_pkg::POS_W'(lin_of(row_nx, col_nx));
						end
					end
				end
			end
			ST_READ: begin
				out_load         = 1'b1;
				out_d.cell_value = rd_data_q;
				state_d          = ST_IDLE;
			end
			ST_FILL: begin
				mem_we = 1'b1;
				addr_d = addr_q + 1'b1;
				if (addr_q == LAST_CELL) begin
					row_d    = '0;
					col_d    = '0;
					out_load = 1'b1;
					out_d.cursor_position = '0;
					state_d  = ST_IDLE;
				end
			end
			ST_COPY: begin
				mem_re  = 1'b1;
				mem_we  = wpend_q;
				mem_wa  = waddr_q;
				mem_wd  = rd_data_q;
				waddr_d = addr_q;
				wpend_d = 1'b1;
				addr_d  = addr_q + 1'b1;
				if (addr_q == LAST_SRC) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				mem_we  = 1'b1;
				mem_wa  = waddr_q;
				mem_wd  = rd_data_q;
				wpend_d = 1'b0;
				addr_d  = BOTTOM_ROW;
				state_d = ST_BLANK;
			end
			ST_BLANK: begin
				mem_we = 1'b1;
				addr_d = addr_q + 1'b1;
				if (addr_q == LAST_CELL) begin
					out_load       = 1'b1;
					out_d.scrolled = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_data_q <= mem_q[mem_ra];
		end
	end

	always_ff @(posedge clk) begin
		waddr_q <= waddr_d;
		if (out_load) begin
			out_q <= out_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			addr_q      <= '0;
			wpend_q     <= 1'b0;
			row_q       <= '0;
			col_q       <= '0;
			attr_q      <= tmtw_pkg::RESET_ATTR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			addr_q  <= addr_d;
			wpend_q <= wpend_d;
			row_q   <= row_d;
			col_q   <= col_d;
			if (cfg_valid && cfg_ready) begin
				attr_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_INIT) |-> ((ROW_W+1)'(row_q) < (ROW_W+1)'(SCREEN_HEIGHT)
			&& (COL_W+1)'(col_q) < (COL_W+1)'(SCREEN_WIDTH)))
		else $error("cursor outside the screen");

	a_copy_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && mem_re) |-> (mem_wa != mem_ra))
		else $error("screen store read and written at one address");

	a_scroll_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && out_d.scrolled) |->
			(out_d.cursor_position == tmtw_pkg::POS_W'((SCREEN_HEIGHT - 1) * SCREEN_WIDTH)))
		else $error("scroll result does not home cursor to bottom row");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || m_tready))
		else $error("result overwrites a beat not yet taken");
`endif

endmodule

`default_nettype wire

### hw/rtl/text_mode_terminal_writer.sv
`default_nettype none

// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid/s_tready    tdata: char_code, cell_index; tuser: mode
// m_*       out        m_tvalid/m_tready    tdata: cursor_position, cell_value, scrolled
// cfg_*     in         cfg_valid/cfg_ready  cfg_data: text_attribute
//
// A beat is registered in the two-entry command queue; put, control characters,
// unused mode and out-of-range reads are then answered from the idle state unless they
// scroll, reads via a read state (registered store port). Clear and a scroll go through
// the store one cell per cycle through the single write port.
// After reset a clearing pass blanks the store; no beat is taken from the queue
// meanwhile, and the queue accepts up to two beats.
// A stalled output holds one result while the queue keeps accepting input until full.

module text_mode_terminal_writer #(
	parameter int unsigned SCREEN_WIDTH  = tmtw_pkg::DEF_SCREEN_WIDTH,
	parameter int unsigned SCREEN_HEIGHT = tmtw_pkg::DEF_SCREEN_HEIGHT
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// char_code [7:0], cell_index [18:8], zero fill [23:19]
	input  wire logic [23:0]                   s_tdata,
	// mode [1:0]
	input  wire logic [tmtw_pkg::MODE_W-1:0]   s_tuser,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// cursor_position [10:0], cell_value [26:11], scrolled [27], zero fill [31:28]
	output logic [31:0]                        m_tdata,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [tmtw_pkg::ATTR_W-1:0]   cfg_data
);

	tmtw_pkg::cmd_t    cmd;
	logic              cmd_valid;
	logic              cmd_ready;
	tmtw_pkg::result_t result;

	tmtw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	tmtw_back #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.result    (result)
	);

	assign m_tdata = {4'b0000, result.scrolled, result.cell_value, result.cursor_position};

endmodule

`default_nettype wire
